// ===== hdl/sbfx_pkg.sv =====
// Shared types and operation codes for the soft-bit Q16 arithmetic pipeline.
// No dependencies.
package sbfx_pkg;

  typedef enum logic [1:0] {
    OP_ABSDIFF = 2'd0,
    OP_MUL     = 2'd1,
    OP_DIV     = 2'd2,
    OP_SOFTXOR = 2'd3
  } sbfx_op_t;

  localparam logic [15:0] ONE_Q16     = 16'hFFFF;
  localparam int          STEP_BITS   = 4;

  // Payload carried from stage to stage
  typedef struct packed {
    sbfx_op_t    op;
    logic [15:0] den;
    logic [15:0] rem;
    logic [15:0] quo;
    logic [31:0] prod1;
    logic [31:0] prod2;
    logic [15:0] res;
    logic        dz;
    logic        sat;
  } sbfx_stage_t;

endpackage

// ===== hdl/sbfx_div_step.sv =====
// Four restoring-division steps: shifts four quotient bits into quo.
// Depends on sbfx_pkg.
module sbfx_div_step (
  input  logic [15:0] rem_in,
  input  logic [15:0] den,
  input  logic [15:0] quo_in,
  output logic [15:0] rem_out,
  output logic [15:0] quo_out
);
  import sbfx_pkg::*;

  // Remainder stays below den, so a 17-bit trial covers the shifted value
  always_comb begin
    logic [16:0] trial;
    logic [15:0] r;
    logic [15:0] q;
    r = rem_in;
    q = quo_in;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {r, 1'b0};
      if (trial >= {1'b0, den}) begin
        trial = trial - {1'b0, den};
        q     = {q[14:0], 1'b1};
      end else begin
        q     = {q[14:0], 1'b0};
      end
      r = trial[15:0];
    end
    rem_out = r;
    quo_out = q;
  end

endmodule

// ===== hdl/soft_bit_fixed_point_alu_core.sv =====
// Top level of the soft-bit Q16 arithmetic unit: four-stage pipeline.
// Depends on sbfx_pkg and sbfx_div_step.
//
//  channel | dir | tdata                          | tuser
//  s_axis  | in  | [15:0] operand_a [31:16] op_b  | [1:0] req_type
//  m_axis  | out | [15:0] result_value           | [0] divide_by_zero [1] quotient_saturated
//
// Four register stages; one word enters per cycle while m_axis is not stalled. A word
// moves from st[0] through st[3], and m_axis shows st[3]. The depth is set by the 16-bit
// quotient, built four bits per stage.
// Reset clears the stage valid bits only.
// A stall at the output freezes every stage together; no word is lost.
module soft_bit_fixed_point_alu_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [31:0]            s_tdata,   // operand_a, operand_b
  input  sbfx_pkg::sbfx_op_t     s_tuser,   // req_type
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [15:0]            m_tdata,   // result_value
  output logic [1:0]             m_tuser    // divide_by_zero, quotient_saturated
);
  import sbfx_pkg::*;

  logic        adv;
  logic [3:0]  vld;
  sbfx_stage_t st [4];
  sbfx_stage_t st_next [4];
  logic [15:0] rem_s [4];
  logic [15:0] quo_s [4];

  assign adv      = !vld[3] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[3];
  assign m_tdata  = st[3].res;
  assign m_tuser  = {st[3].sat, st[3].dz};

  sbfx_div_step u_step0 (.rem_in(s_tdata[15:0]), .den(s_tdata[31:16]), .quo_in(16'd0),
                         .rem_out(rem_s[0]), .quo_out(quo_s[0]));

  genvar g;
  generate
    for (g = 1; g < 4; g++) begin : g_step
      sbfx_div_step u_step (.rem_in(st[g-1].rem), .den(st[g-1].den),
                            .quo_in(st[g-1].quo), .rem_out(rem_s[g]), .quo_out(quo_s[g]));
    end
  endgenerate

  always_comb begin
    logic [15:0] a;
    logic [15:0] b;
    a = s_tdata[15:0];
    b = s_tdata[31:16];

    // Input stage: classify divide, absolute difference, first divide steps
    st_next[0]     = '0;
    st_next[0].op  = s_tuser;
    st_next[0].den = b;
    st_next[0].rem = rem_s[0];
    st_next[0].quo = quo_s[0];
    st_next[0].res = (a > b) ? a - b : b - a;
    if (s_tuser == OP_DIV) begin
      st_next[0].dz  = (b == 16'd0);
      st_next[0].sat = (b != 16'd0) && (a >= b);
    end

    // Products: the internal divides by one of the soft xor are identities
    if (s_tuser == OP_MUL) begin
      st_next[0].prod1 = 32'(a) * 32'(b);
    end else if (s_tuser == OP_SOFTXOR) begin
      st_next[0].prod1 = 32'(ONE_Q16 - b) * 32'(a);
      st_next[0].prod2 = 32'(b) * 32'(ONE_Q16 - a);
    end

    // Later stages: sum products, advance the division, select the divide result
    for (int k = 1; k < 4; k++) begin
      st_next[k]     = st[k-1];
      st_next[k].rem = rem_s[k];
      st_next[k].quo = quo_s[k];
    end
    if (st[0].op == OP_MUL || st[0].op == OP_SOFTXOR) begin
      st_next[1].res = st[0].prod1[31:16] + st[0].prod2[31:16];
    end
    if (st[2].op == OP_DIV) begin
      st_next[3].res = (st[2].dz || st[2].sat) ? ONE_Q16 : quo_s[3];
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        st[k] <= st_next[k];
      end
    end
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[2:0], s_tvalid};
    end
  end

endmodule

// ===== hdl/sbfx_checker.sv =====
// Port-level checks for the soft-bit Q16 arithmetic unit, bound to the top.
// Depends on soft_bit_fixed_point_alu_core.
module sbfx_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // Pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid after reset");

  // A zero divisor always reads as full scale
  a_dz_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 16'hFFFF))
    else $error("divide by zero without full-scale result");

  // Clamped quotient reads as full scale
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata == 16'hFFFF))
    else $error("saturated quotient not full scale");

  // The two flags never come together
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("both divide flags set");

  // Hold a stalled word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled output word changed");

endmodule

bind soft_bit_fixed_point_alu_core sbfx_checker u_sbfx_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser)
);

// ===== test/soft_bit_fixed_point_alu_core_test.sv =====
// Self-checking bench for the soft-bit Q16 arithmetic unit: directed and random words,
// with idle and stall phases on both streams. Depends on sbfx_pkg and the core RTL.
`timescale 1ns / 1ps

module soft_bit_fixed_point_alu_core_test;
  import sbfx_pkg::*;

  typedef struct {
    logic [15:0] value;
    logic        dz;
    logic        sat;
  } alu_result_t;

  // Expected-result store with its own Q16 arithmetic
  class alu_scoreboard;
    alu_result_t pending[$];
    int          errors;
    int          checked;
    int          op_seen[4];

    function automatic logic [15:0] qmul(logic [15:0] a, logic [15:0] b);
      logic [31:0] p;
      p = {16'd0, a} * {16'd0, b};
      return p[31:16];
    endfunction

    function automatic logic [15:0] qdiv(logic [15:0] a, logic [15:0] b,
                                         output logic dz, output logic sat);
      logic [31:0] q;
      dz = 1'b0;
      sat = 1'b0;
      if (b == 16'd0) begin
        dz = 1'b1;
        return ONE_Q16;
      end
      q = {a, 16'd0} / {16'd0, b};
      if (q > {16'd0, ONE_Q16}) begin
        sat = 1'b1;
        return ONE_Q16;
      end
      return q[15:0];
    endfunction

    // Compute the expected result of one accepted word
    function void note_request(sbfx_op_t op, logic [15:0] a, logic [15:0] b);
      alu_result_t r;
      logic z, c;
      logic [15:0] t1, t2;
      r.dz = 1'b0;
      r.sat = 1'b0;
      op_seen[op]++;
      case (op)
        OP_ABSDIFF: r.value = (a > b) ? a - b : b - a;
        OP_MUL:     r.value = qmul(a, b);
        OP_DIV:     r.value = qdiv(a, b, r.dz, r.sat);
        default: begin
          t1 = qmul(qdiv(ONE_Q16 - b, ONE_Q16, z, c), qdiv(a, ONE_Q16, z, c));
          t2 = qmul(qdiv(b, ONE_Q16, z, c), qdiv(ONE_Q16 - a, ONE_Q16, z, c));
          r.value = t1 + t2;
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [15:0] value, logic dz, logic sat);
      alu_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word: value %h", value);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (value !== e.value) begin
        $error("result_value: expected %h, got %h", e.value, value);
        errors++;
      end
      if (dz !== e.dz) begin
        $error("divide_by_zero: expected %b, got %b", e.dz, dz);
        errors++;
      end
      if (sat !== e.sat) begin
        $error("quotient_saturated: expected %b, got %b", e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  sbfx_op_t    s_tuser = OP_ABSDIFF;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;

  int          idle_pct = 0;
  int          stall_pct = 0;
  alu_scoreboard sb = new();

  soft_bit_fixed_point_alu_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #10 clk = ~clk;

  // Check each result word and pick the next stall
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0], m_tuser[1]);
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Note each accepted request
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata[15:0], s_tdata[31:16]);
  end

  // Present one word, with a random idle gap first, and hold it until taken
  task automatic send_word(sbfx_op_t op, logic [15:0] a, logic [15:0] b);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic go_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the sender until every result is back
  task automatic drain();
    go_idle();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(15));
      3: return 16'hFFFF - 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] edges[5];
    edges = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFE, 16'hFFFF};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: each op at the extremes, divide by zero, clamped quotient
    for (int i = 0; i < 5; i++) begin
      send_word(sbfx_op_t'(i % 4), edges[i], edges[4 - i]);
    end
    send_word(OP_DIV, 16'h1234, 16'h0000);
    send_word(OP_DIV, 16'h0000, 16'h0000);
    send_word(OP_DIV, 16'hFFFF, 16'h0001);
    send_word(OP_DIV, 16'h8000, 16'h8000);
    send_word(OP_DIV, 16'h7FFF, 16'h8000);
    send_word(OP_MUL, 16'hFFFF, 16'hFFFF);
    send_word(OP_ABSDIFF, 16'h0000, 16'hFFFF);
    send_word(OP_ABSDIFF, 16'hFFFF, 16'h0000);
    send_word(OP_SOFTXOR, 16'hFFFF, 16'hFFFF);
    send_word(OP_SOFTXOR, 16'hFFFF, 16'h0000);
    send_word(OP_SOFTXOR, 16'h0000, 16'hFFFF);
    send_word(OP_SOFTXOR, 16'h8000, 16'h8000);
    drain();

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 86 : (ph == 3) ? 27 : 0;
      stall_pct = (ph == 2) ? 86 : (ph == 3) ? 27 : 0;
      for (int n = 0; n < 250; n++) begin
        send_word(sbfx_op_t'($urandom_range(3)), pick_operand(), pick_operand());
      end
      drain();
    end

    stall_pct = 0;
    repeat (10) @(posedge clk);
    $display("Covered %0d results: absdiff %0d, mul %0d, div %0d, soft xor %0d",
             sb.checked, sb.op_seen[0], sb.op_seen[1], sb.op_seen[2], sb.op_seen[3]);
    $display("across idle and stall phases on both streams.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("soft_bit_fixed_point_alu_core_test OK");
    end else begin
      $display("soft_bit_fixed_point_alu_core_test NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("soft_bit_fixed_point_alu_core_test NOT OK");
    $finish;
  end

endmodule
